// ===== design/mfs_pkg.sv =====
// Shared constants, types and helpers for the message queue with search.
package mfs_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int REQ_W       = 2;
    localparam int SRC_W       = 16;
    localparam int MSG_W       = 32;
    localparam int PRI_W       = 8;
    localparam int OCC_W       = 5;

    typedef logic [IDX_W-1:0] t_idx;
    typedef logic [CNT_W-1:0] t_cnt;

    typedef enum logic [REQ_W-1:0] {
        REQ_ENQUEUE = 2'd0,
        REQ_DEQUEUE = 2'd1,
        REQ_SEARCH  = 2'd2,
        REQ_CLEAR   = 2'd3
    } t_req;

    typedef struct packed {
        logic        [SRC_W-1:0] source;
        logic signed [MSG_W-1:0] message;
        logic        [PRI_W-1:0] prio;
    } t_entry;

    typedef struct packed {
        logic               ok;
        t_entry             entry;
        logic [OCC_W-1:0]   occupancy;
    } t_res;

    typedef struct packed {
        logic done;
        t_res res;
    } t_res_bus;

    function automatic t_idx next_slot(t_idx idx);
        return (idx == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : t_idx'(idx + 1'b1);
    endfunction

endpackage

// ===== design/mfs_ifs.sv =====
// Request and response channel interfaces for the message queue.
interface mfs_req_if;
    logic                                valid;
    logic                                ready;
    logic        [mfs_pkg::REQ_W-1:0]    req_type;
    logic        [mfs_pkg::SRC_W-1:0]    source_in;
    logic signed [mfs_pkg::MSG_W-1:0]    message_in;
    logic        [mfs_pkg::PRI_W-1:0]    priority_in;

    modport source (output valid, req_type, source_in, message_in, priority_in,
                    input ready);
    modport sink   (input valid, req_type, source_in, message_in, priority_in,
                    output ready);
endinterface

interface mfs_rsp_if;
    logic                                valid;
    logic                                ready;
    logic                                ok;
    logic        [mfs_pkg::SRC_W-1:0]    source_out;
    logic signed [mfs_pkg::MSG_W-1:0]    message_out;
    logic        [mfs_pkg::PRI_W-1:0]    priority_out;
    logic        [mfs_pkg::OCC_W-1:0]    occupancy;

    modport source (output valid, ok, source_out, message_out, priority_out,
                    occupancy, input ready);
    modport sink   (input valid, ok, source_out, message_out, priority_out,
                    occupancy, output ready);
endinterface

// ===== design/message_fifo_with_search_unit.sv =====
// Message queue with search: top level with the response output register.
//
// i_req carries one request beat: req_type (enqueue, dequeue, search, clear)
// with source_in, message_in and priority_in. o_rsp returns exactly one beat
// per request: ok, source_out, message_out, priority_out and occupancy.
// Entries leave in arrival order; priority is stored and returned only.
// The block takes one request at a time and drops i_req.ready until the
// request has reached the output register.
// Enqueue, clear, and a dequeue or search on an empty queue go straight to
// the done state; a dequeue first reads the front entry, and a search scans
// from the front until a match (the shared key comparator reads one entry per
// cycle from the entry memory, up to the occupancy).
// A new request is taken the cycle after its response is loaded.
// Reset empties the queue at once; stored entries are not cleared.
// When the receiver stalls, the response holds in the output register; the
// next request may still be taken, and its response waits until the held
// beat is taken.
module message_fifo_with_search_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mfs_req_if.sink    i_req,
    mfs_rsp_if.source  o_rsp
);

    logic               wr_en;
    mfs_pkg::t_idx      wr_addr;
    mfs_pkg::t_entry    wr_entry;
    mfs_pkg::t_idx      rd_addr;
    mfs_pkg::t_entry    rd_entry;
    mfs_pkg::t_res_bus  res;
    logic               res_ready;

    logic               r_out_valid;
    mfs_pkg::t_res      r_out;

    mfs_store u_store (
        .i_clk      (i_clk),
        .i_wr_en    (wr_en),
        .i_wr_addr  (wr_addr),
        .i_wr_entry (wr_entry),
        .i_rd_addr  (rd_addr),
        .o_rd_entry (rd_entry)
    );

    mfs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_entry  (wr_entry),
        .o_rd_addr   (rd_addr),
        .i_rd_entry  (rd_entry),
        .o_res       (res),
        .i_res_ready (res_ready)
    );

    assign res_ready = !r_out_valid || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res.done && res_ready) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res.done && res_ready) begin
            r_out <= res.res;
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.ok           = r_out.ok;
    assign o_rsp.source_out   = r_out.entry.source;
    assign o_rsp.message_out  = r_out.entry.message;
    assign o_rsp.priority_out = r_out.entry.prio;
    assign o_rsp.occupancy    = r_out.occupancy;

endmodule

// ===== design/mfs_store.sv =====
// Entry storage: one write port and one registered read port.
module mfs_store (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  mfs_pkg::t_idx     i_wr_addr,
    input  mfs_pkg::t_entry   i_wr_entry,
    input  mfs_pkg::t_idx     i_rd_addr,
    output mfs_pkg::t_entry   o_rd_entry
);

    mfs_pkg::t_entry r_mem [mfs_pkg::QUEUE_DEPTH];
    mfs_pkg::t_entry r_rd_entry;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_entry;
        end
        r_rd_entry <= r_mem[i_rd_addr];
    end

    assign o_rd_entry = r_rd_entry;

endmodule

// ===== design/mfs_ctrl.sv =====
// Request sequencer: queue pointers, scan loop and shared key compare.
module mfs_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    mfs_req_if.sink              i_req,
    output logic                 o_wr_en,
    output mfs_pkg::t_idx        o_wr_addr,
    output mfs_pkg::t_entry      o_wr_entry,
    output mfs_pkg::t_idx        o_rd_addr,
    input  mfs_pkg::t_entry      i_rd_entry,
    output mfs_pkg::t_res_bus    o_res,
    input  logic                 i_res_ready
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DEQ  = 4'b0010,
        S_SCAN = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state                         r_state, n_state;
    mfs_pkg::t_idx                  r_front, n_front;
    mfs_pkg::t_idx                  r_tail, n_tail;
    mfs_pkg::t_cnt                  r_count, n_count;
    mfs_pkg::t_idx                  r_pos, n_pos;
    mfs_pkg::t_cnt                  r_left, n_left;
    logic signed [mfs_pkg::MSG_W-1:0] r_key, n_key;
    logic                           r_ok, n_ok;
    mfs_pkg::t_entry                r_entry, n_entry;

    logic          accept;
    logic          full;
    logic          empty;
    mfs_pkg::t_req req;

    assign i_req.ready = (r_state == S_IDLE);
    assign accept      = i_req.valid && i_req.ready;
    assign req         = mfs_pkg::t_req'(i_req.req_type);
    assign full        = (r_count == mfs_pkg::CNT_W'(mfs_pkg::QUEUE_DEPTH));
    assign empty       = (r_count == '0);

    assign o_wr_en    = accept && (req == mfs_pkg::REQ_ENQUEUE) && !full;
    assign o_wr_addr  = r_tail;
    assign o_wr_entry = '{source: i_req.source_in, message: i_req.message_in,
                          prio: i_req.priority_in};
    assign o_rd_addr  = (r_state == S_SCAN) ? mfs_pkg::next_slot(r_pos) : r_front;

    assign o_res.done          = (r_state == S_DONE);
    assign o_res.res.ok        = r_ok;
    assign o_res.res.entry     = r_entry;
    assign o_res.res.occupancy = mfs_pkg::OCC_W'(r_count);

    always_comb begin
        n_state = r_state;
        n_front = r_front;
        n_tail  = r_tail;
        n_count = r_count;
        n_pos   = r_pos;
        n_left  = r_left;
        n_key   = r_key;
        n_ok    = r_ok;
        n_entry = r_entry;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_ok    = 1'b0;
                    n_entry = '0;
                    n_state = S_DONE;
                    case (req)
                        mfs_pkg::REQ_ENQUEUE: begin
                            if (!full) begin
                                n_tail  = mfs_pkg::next_slot(r_tail);
                                n_count = mfs_pkg::t_cnt'(r_count + 1'b1);
                                n_ok    = 1'b1;
                            end
                        end
                        mfs_pkg::REQ_DEQUEUE: begin
                            if (!empty) begin
                                n_state = S_DEQ;
                            end
                        end
                        mfs_pkg::REQ_SEARCH: begin
                            if (!empty) begin
                                n_pos   = r_front;
                                n_left  = r_count;
                                n_key   = i_req.message_in;
                                n_state = S_SCAN;
                            end
                        end
                        default: begin
                            n_front = '0;
                            n_tail  = '0;
                            n_count = '0;
                            n_ok    = 1'b1;
                        end
                    endcase
                end
            end
            S_DEQ: begin
                n_entry = i_rd_entry;
                n_ok    = 1'b1;
                n_front = mfs_pkg::next_slot(r_front);
                n_count = mfs_pkg::t_cnt'(r_count - 1'b1);
                n_state = S_DONE;
            end
            S_SCAN: begin
                if (i_rd_entry.message == r_key) begin
                    n_entry = i_rd_entry;
                    n_ok    = 1'b1;
                    n_state = S_DONE;
                end else if (r_left == mfs_pkg::CNT_W'(1)) begin
                    n_state = S_DONE;
                end else begin
                    n_left = mfs_pkg::t_cnt'(r_left - 1'b1);
                    n_pos  = mfs_pkg::next_slot(r_pos);
                end
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_front <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_front <= n_front;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos   <= n_pos;
        r_left  <= n_left;
        r_key   <= n_key;
        r_ok    <= n_ok;
        r_entry <= n_entry;
    end

endmodule

// ===== design/mfs_checker.sv =====
// Port-level assertions for the message queue, bound to the top level.
module mfs_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_req_valid,
    input logic                              i_req_ready,
    input logic                              i_rsp_valid,
    input logic                              i_rsp_ready,
    input logic                              i_rsp_ok,
    input logic        [mfs_pkg::SRC_W-1:0]  i_rsp_source,
    input logic signed [mfs_pkg::MSG_W-1:0]  i_rsp_message,
    input logic        [mfs_pkg::PRI_W-1:0]  i_rsp_priority,
    input logic        [mfs_pkg::OCC_W-1:0]  i_rsp_occupancy
);

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_ok)
            && $stable(i_rsp_source) && $stable(i_rsp_message)
            && $stable(i_rsp_priority) && $stable(i_rsp_occupancy))
        else $error("response beat changed while stalled");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("request taken while another is in progress");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ok |-> i_rsp_source == '0 && i_rsp_message == '0
            && i_rsp_priority == '0)
        else $error("refused request returned entry fields");

endmodule

bind message_fifo_with_search_unit mfs_checker u_mfs_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_req_valid     (i_req.valid),
    .i_req_ready     (i_req.ready),
    .i_rsp_valid     (o_rsp.valid),
    .i_rsp_ready     (o_rsp.ready),
    .i_rsp_ok        (o_rsp.ok),
    .i_rsp_source    (o_rsp.source_out),
    .i_rsp_message   (o_rsp.message_out),
    .i_rsp_priority  (o_rsp.priority_out),
    .i_rsp_occupancy (o_rsp.occupancy)
);

// ===== tb/message_fifo_with_search_unit_tb.sv =====
// Testbench for the message queue with search: directed script, random traffic, FIFO model.
module message_fifo_with_search_unit_tb;
    import mfs_pkg::*;

    typedef enum logic [1:0] {RX_EAGER, RX_COIN, RX_SPARSE, RX_MOSTLY} t_rx_mode;
    typedef enum logic [1:0] {MIX_FILL, MIX_DRAIN, MIX_EVEN} t_mix;

    typedef struct packed {
        t_req             req;
        logic [SRC_W-1:0] src;
        logic [MSG_W-1:0] msg;
        logic [PRI_W-1:0] pri;
        logic [4:0]       reps;
        logic             fixed;
        t_res             rsp;
    } t_step;

    localparam int SCRIPT_LEN = 23;
    localparam int RANDOM_ITEMS = 1400;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    mfs_req_if req_if ();
    mfs_rsp_if rsp_if ();

    message_fifo_with_search_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    always #5 i_clk = ~i_clk;

    t_entry           q_slots [QUEUE_DEPTH];
    int               q_head = 0;
    int               q_tail = 0;
    int               q_fill = 0;
    t_res             awaited_rsp [$];
    t_res             predicted;
    t_res             got;
    bit               fixed_due = 1'b0;
    t_res             fixed_rsp = '0;
    int               errors = 0;
    int               beat_no = 0;
    int               burst_left = 4;
    bit               hold_ask = 1'b0;
    int               hold_left = 0;
    int               mode_left = 0;
    int               tick = 0;
    t_rx_mode         stall_mode = RX_EAGER;
    logic [MSG_W-1:0] key_pool [6] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000,
                                       32'h7FFF_FFFF, 32'h0000_0005, 32'hDEAD_BEEF};
    t_step            script [SCRIPT_LEN];

    function automatic t_res bare_rsp(logic ok, logic [OCC_W-1:0] occ);
        t_res r;
        r = '0;
        r.ok = ok;
        r.occupancy = occ;
        return r;
    endfunction

    function automatic t_res predict_rsp(t_req req, logic [SRC_W-1:0] src,
                                         logic [MSG_W-1:0] msg, logic [PRI_W-1:0] pri);
        t_res r;
        int   pos;
        bit   found;
        r = '0;
        found = 1'b0;
        case (req)
            REQ_ENQUEUE: begin
                if (q_fill < QUEUE_DEPTH) begin
                    q_slots[q_tail] = '{src, msg, pri};
                    q_tail = (q_tail == QUEUE_DEPTH - 1) ? 0 : q_tail + 1;
                    q_fill++;
                    r.ok = 1'b1;
                end
            end
            REQ_DEQUEUE: begin
                if (q_fill > 0) begin
                    r.entry = q_slots[q_head];
                    q_head = (q_head == QUEUE_DEPTH - 1) ? 0 : q_head + 1;
                    q_fill--;
                    r.ok = 1'b1;
                end
            end
            REQ_SEARCH: begin
                pos = q_head;
                for (int i = 0; i < q_fill; i++) begin
                    if (!found && q_slots[pos].message == msg) begin
                        r.entry = q_slots[pos];
                        r.ok = 1'b1;
                        found = 1'b1;
                    end
                    pos = (pos == QUEUE_DEPTH - 1) ? 0 : pos + 1;
                end
            end
            default: begin
                q_head = 0;
                q_tail = 0;
                q_fill = 0;
                r.ok = 1'b1;
            end
        endcase
        r.occupancy = OCC_W'(q_fill);
        return r;
    endfunction

    task automatic report_mismatch(string field, logic [63:0] seen, logic [63:0] want);
        $display("response beat %0d: %s got %0h expected %0h", beat_no, field, seen, want);
        errors++;
    endtask

    task automatic check_rsp(t_res seen, t_res want);
        if (seen.ok !== want.ok)
            report_mismatch("ok", seen.ok, want.ok);
        if (seen.entry.source !== want.entry.source)
            report_mismatch("source_out", seen.entry.source, want.entry.source);
        if (seen.entry.message !== want.entry.message)
            report_mismatch("message_out", seen.entry.message, want.entry.message);
        if (seen.entry.prio !== want.entry.prio)
            report_mismatch("priority_out", seen.entry.prio, want.entry.prio);
        if (seen.occupancy !== want.occupancy)
            report_mismatch("occupancy", seen.occupancy, want.occupancy);
    endtask

    // called at a falling edge; returns at a falling edge after the beat (later when a burst ends)
    task automatic offer(t_req r, logic [SRC_W-1:0] s, logic [MSG_W-1:0] m,
                         logic [PRI_W-1:0] p);
        req_if.valid = 1'b1;
        req_if.req_type = r;
        req_if.source_in = s;
        req_if.message_in = m;
        req_if.priority_in = p;
        do @(posedge i_clk); while (!req_if.ready);
        @(negedge i_clk);
        burst_left--;
        if (burst_left <= 0) begin
            req_if.valid = 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge i_clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(1, 12);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (req_if.valid && req_if.ready) begin
                predicted = predict_rsp(t_req'(req_if.req_type), req_if.source_in,
                                        req_if.message_in, req_if.priority_in);
                awaited_rsp.push_back(fixed_due ? fixed_rsp : predicted);
            end
            if (rsp_if.valid && rsp_if.ready) begin
                got = '{rsp_if.ok,
                        '{rsp_if.source_out, rsp_if.message_out, rsp_if.priority_out},
                        rsp_if.occupancy};
                beat_no++;
                if (awaited_rsp.size() == 0)
                    report_mismatch("unexpected beat", 64'd1, 64'd0);
                else
                    check_rsp(got, awaited_rsp.pop_front());
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready = 1'b0;
        end else if (hold_left != 0) begin
            rsp_if.ready = 1'b0;
            hold_left--;
        end else if (hold_ask) begin
            hold_ask = 1'b0;
            hold_left = 299;
            rsp_if.ready = 1'b0;
        end else begin
            if (mode_left == 0) begin
                stall_mode = t_rx_mode'($urandom_range(0, 3));
                mode_left = $urandom_range(40, 400);
            end
            mode_left--;
            tick++;
            case (stall_mode)
                RX_EAGER:  rsp_if.ready = 1'b1;
                RX_COIN:   rsp_if.ready = 1'($urandom_range(0, 1));
                RX_SPARSE: rsp_if.ready = (tick % 5 == 0);
                default:   rsp_if.ready = ($urandom_range(0, 9) != 0);
            endcase
        end
    end

    initial begin
        #3_000_000;
        $display("message_fifo_with_search_unit_tb: FAIL");
        $finish;
    end

    initial begin
        t_req             op;
        t_mix             mix;
        logic [MSG_W-1:0] key;
        int               roll;
        int               enq_cut;
        int               deq_cut;
        int               srch_cut;

        req_if.valid = 1'b0;
        req_if.req_type = REQ_ENQUEUE;
        req_if.source_in = '0;
        req_if.message_in = '0;
        req_if.priority_in = '0;

        script = '{
            '{REQ_DEQUEUE, 16'h0000, 32'h0000_0000, 8'h00, 5'd1,  1'b1, bare_rsp(0, 0)},
            '{REQ_SEARCH,  16'h0000, 32'h0000_0000, 8'h00, 5'd1,  1'b1, bare_rsp(0, 0)},
            '{REQ_ENQUEUE, 16'hFFFF, 32'h7FFF_FFFF, 8'hFF, 5'd1,  1'b1, bare_rsp(1, 1)},
            '{REQ_ENQUEUE, 16'h0000, 32'h8000_0000, 8'h00, 5'd1,  1'b1, bare_rsp(1, 2)},
            '{REQ_SEARCH,  16'h0000, 32'h8000_0000, 8'h00, 5'd1,  1'b0, bare_rsp(0, 0)},
            '{REQ_SEARCH,  16'h0000, 32'h7FFF_FFFF, 8'h00, 5'd1,  1'b0, bare_rsp(0, 0)},
            '{REQ_SEARCH,  16'h0000, 32'h0000_0000, 8'h00, 5'd1,  1'b0, bare_rsp(0, 0)},
            '{REQ_DEQUEUE, 16'h0000, 32'h0000_0000, 8'h00, 5'd1,  1'b0, bare_rsp(0, 0)},
            '{REQ_ENQUEUE, 16'h0100, 32'h0000_0005, 8'h11, 5'd14, 1'b0, bare_rsp(0, 0)},
            '{REQ_ENQUEUE, 16'h0200, 32'h0000_0005, 8'h22, 5'd1,  1'b0, bare_rsp(0, 0)},
            '{REQ_ENQUEUE, 16'h0300, 32'h1234_5678, 8'h33, 5'd1,  1'b1, bare_rsp(0, 16)},
            '{REQ_SEARCH,  16'h0000, 32'h0000_0005, 8'h00, 5'd1,  1'b0, bare_rsp(0, 0)},
            '{REQ_SEARCH,  16'h0000, 32'h8000_0000, 8'h00, 5'd1,  1'b0, bare_rsp(0, 0)},
            '{REQ_DEQUEUE, 16'h0000, 32'h0000_0000, 8'h00, 5'd3,  1'b0, bare_rsp(0, 0)},
            '{REQ_ENQUEUE, 16'hAAAA, 32'h5555_5555, 8'hAA, 5'd3,  1'b0, bare_rsp(0, 0)},
            '{REQ_SEARCH,  16'h0000, 32'h5555_5555, 8'h00, 5'd1,  1'b0, bare_rsp(0, 0)},
            '{REQ_SEARCH,  16'h0000, 32'hFFFF_FFFF, 8'h00, 5'd1,  1'b0, bare_rsp(0, 0)},
            '{REQ_CLEAR,   16'h0000, 32'h0000_0000, 8'h00, 5'd1,  1'b1, bare_rsp(1, 0)},
            '{REQ_DEQUEUE, 16'h0000, 32'h0000_0000, 8'h00, 5'd1,  1'b1, bare_rsp(0, 0)},
            '{REQ_SEARCH,  16'h0000, 32'h0000_0005, 8'h00, 5'd1,  1'b1, bare_rsp(0, 0)},
            '{REQ_ENQUEUE, 16'h5555, 32'hAAAA_AAAA, 8'h55, 5'd1,  1'b1, bare_rsp(1, 1)},
            '{REQ_DEQUEUE, 16'h0000, 32'h0000_0000, 8'h00, 5'd1,  1'b0, bare_rsp(0, 0)},
            '{REQ_CLEAR,   16'h0000, 32'h0000_0000, 8'h00, 5'd1,  1'b1, bare_rsp(1, 0)}
        };

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        foreach (script[i]) begin
            for (int k = 0; k < script[i].reps; k++) begin
                fixed_due = script[i].fixed;
                fixed_rsp = script[i].rsp;
                offer(script[i].req, script[i].src + SRC_W'(k), script[i].msg, script[i].pri);
                fixed_due = 1'b0;
            end
        end

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == 300)
                hold_ask = 1'b1;
            if (n == 700) begin
                req_if.valid = 1'b0;
                while (awaited_rsp.size() != 0) @(negedge i_clk);
            end
            mix = t_mix'((n / 100) % 3);
            case (mix)
                MIX_FILL: begin
                    enq_cut = 55; deq_cut = 70; srch_cut = 98;
                end
                MIX_DRAIN: begin
                    enq_cut = 20; deq_cut = 70; srch_cut = 98;
                end
                default: begin
                    enq_cut = 35; deq_cut = 65; srch_cut = 98;
                end
            endcase
            roll = $urandom_range(0, 99);
            if (roll < enq_cut)
                op = REQ_ENQUEUE;
            else if (roll < deq_cut)
                op = REQ_DEQUEUE;
            else if (roll < srch_cut)
                op = REQ_SEARCH;
            else
                op = REQ_CLEAR;
            key = $urandom_range(0, 1) ? MSG_W'($urandom) : key_pool[$urandom_range(0, 5)];
            if (op == REQ_SEARCH && q_fill != 0 && $urandom_range(0, 9) < 7)
                key = q_slots[(q_head + $urandom_range(0, q_fill - 1)) % QUEUE_DEPTH].message;
            offer(op, SRC_W'($urandom), key, PRI_W'($urandom));
        end

        req_if.valid = 1'b0;
        while (awaited_rsp.size() != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
        if (errors == 0)
            $display("message_fifo_with_search_unit_tb: PASS");
        else
            $display("message_fifo_with_search_unit_tb: FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
design/mfs_pkg.sv
design/mfs_ifs.sv
design/mfs_store.sv
design/mfs_ctrl.sv
design/message_fifo_with_search_unit.sv
design/mfs_checker.sv
tb/message_fifo_with_search_unit_tb.sv
